FILE: hw/rtl/substring_first_last_search_core_defines.svh
// ---------------------------------------------------------------------------
// Substring search assertion macros
// Shared concurrent assertion forms for the substring search core.
// ---------------------------------------------------------------------------
`ifndef SUBSTRING_FIRST_LAST_SEARCH_CORE_DEFINES_SVH
`define SUBSTRING_FIRST_LAST_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SFLS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sfls assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sfls assertion failed");

`else

`define SFLS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SFLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hw/rtl/sfls_pkg.sv
// ---------------------------------------------------------------------------
// Substring search package
// Shared constants, codes, types and the pattern byte selector.
// ---------------------------------------------------------------------------
`default_nettype none

package sfls_pkg;

    localparam int CFG_DATA_W = 64;
    localparam int LEN_REG_W  = 5;
    localparam int PAT_IDX_W  = 6;
    localparam int MATCH_W    = 32;

    typedef enum logic [1:0] {
        CFG_PATTERN_LOW      = 2'd0,
        CFG_PATTERN_HIGH     = 2'd1,
        CFG_PATTERN_LENGTH   = 2'd2,
        CFG_SEARCH_DIRECTION = 2'd3
    } t_cfg_addr;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TOO_LONG  = 2'd2
    } t_status;

    typedef struct packed {
        logic advance;
        logic last;
    } t_step;

    typedef struct packed {
        logic               found;
        logic [MATCH_W-1:0] match_index;
        t_status            status;
    } t_result;

    // Pattern bytes past the two configuration words read as zero.
    function automatic logic [7:0] pattern_byte(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [PAT_IDX_W-1:0]  k
    );
        logic [7:0] b;
        b = '0;
        if (k < PAT_IDX_W'(8)) begin
            b = lo[{k[2:0], 3'b000} +: 8];
        end else if (k < PAT_IDX_W'(16)) begin
            b = hi[{k[2:0], 3'b000} +: 8];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sfls_in_if.sv
// ---------------------------------------------------------------------------
// Substring search input channel
// Valid/ready channel carrying one text byte and its end-of-text flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface sfls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sfls_out_if.sv
// ---------------------------------------------------------------------------
// Substring search result channel
// Valid/ready channel carrying one search result per text.
// ---------------------------------------------------------------------------
`default_nettype none

interface sfls_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_index;
    logic [1:0]  status;

    modport source (output valid, output found, output match_index, output status, input ready);
    modport sink (input valid, input found, input match_index, input status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sfls_window.sv
// ---------------------------------------------------------------------------
// Substring search window
// Shift line of recent text bytes and the parallel compare with the pattern.
// ---------------------------------------------------------------------------
`default_nettype none

module sfls_window
    import sfls_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int LEN_W       = 5
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  t_step                      i_step,
    input  wire  [7:0]                 i_byte,
    input  wire  [CFG_DATA_W-1:0]      i_pat_lo,
    input  wire  [CFG_DATA_W-1:0]      i_pat_hi,
    input  wire  [LEN_W-1:0]           i_plen,
    output logic                       o_hit
);

    logic [7:0] r_recent [MAX_PATTERN];
    logic [7:0] n_window [MAX_PATTERN];

    always_comb begin
        n_window[0] = i_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_window[j] = r_recent[j-1];
        end
    end

    // Window entry j lines up with pattern byte plen-1-j.
    always_comb begin
        logic [LEN_W-1:0] pidx;
        o_hit = 1'b1;
        pidx  = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (LEN_W'(j) < i_plen) begin
                pidx = i_plen - LEN_W'(1) - LEN_W'(j);
                if (n_window[j] != pattern_byte(i_pat_lo, i_pat_hi, PAT_IDX_W'(pidx))) begin
                    o_hit = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_recent[j] <= '0;
            end
        end else if (i_step.advance) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_recent[j] <= i_step.last ? 8'd0 : n_window[j];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sfls_track.sv
// ---------------------------------------------------------------------------
// Substring search tracker
// Byte count, kept match start and the end-of-text result.
// ---------------------------------------------------------------------------
`default_nettype none

module sfls_track
    import sfls_pkg::*;
#(
    parameter int INDEX_WIDTH = 32,
    parameter int LEN_W       = 5
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_step            i_step,
    input  wire              i_hit,
    input  wire  [LEN_W-1:0] i_plen,
    input  wire              i_dir,
    output t_result          o_result
);

    logic [INDEX_WIDTH-1:0] r_seen;
    logic                   r_match;
    logic [INDEX_WIDTH-1:0] r_start;
    logic [INDEX_WIDTH-1:0] n_seen;
    logic                   n_match;
    logic [INDEX_WIDTH-1:0] n_start;
    logic [INDEX_WIDTH-1:0] plen_ext;
    logic                   eligible;
    logic                   take;

    always_comb begin
        plen_ext = INDEX_WIDTH'(i_plen);
        n_seen   = (&r_seen) ? r_seen : r_seen + INDEX_WIDTH'(1);
        eligible = n_seen >= plen_ext;
        take     = eligible && i_hit && (i_dir || !r_match);
        n_match  = r_match || take;
        n_start  = take ? n_seen - plen_ext : r_start;
    end

    always_comb begin
        o_result = '0;
        if (!eligible) begin
            o_result.status = ST_TOO_LONG;
        end else if (n_match) begin
            o_result.found       = 1'b1;
            o_result.match_index = MATCH_W'(n_start);
            o_result.status      = ST_FOUND;
        end else begin
            o_result.status = ST_NOT_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_match <= 1'b0;
            r_start <= '0;
        end else if (i_step.advance) begin
            if (i_step.last) begin
                r_seen  <= '0;
                r_match <= 1'b0;
                r_start <= '0;
            end else begin
                r_seen  <= n_seen;
                r_match <= n_match;
                r_start <= n_start;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/substring_first_last_search_core.sv
// ---------------------------------------------------------------------------
// Substring first/last search core
// Streams text bytes and reports the first or last match of a short pattern.
// ---------------------------------------------------------------------------
// Text enters on i_in one byte per word; last_byte marks the end of a text.
// One result word leaves on o_out for each text, carrying found, the match
// start offset and a status code (found, not found, pattern longer than text).
// Bytes that are not the last of a text produce no result word.
// The user writes the pattern, its length and the search direction through
// the configuration port only while no text is in flight; the block itself
// does not enforce this. A byte is held in an input register and then
// processed: the window compare and the match tracking run in one
// combinational stage feeding the result register. The result word is valid
// once the final byte has left the input register and its result has been
// loaded into the result register. One byte is taken every cycle while no final byte is held.
// If the result register is full and o_out is stalled, a final byte waits in
// the input register and i_in drops ready; ordinary bytes keep flowing.
// Synchronous reset clears the window, the counters, the pipeline valids and
// restores the pattern length to one and the direction to first match.
// ---------------------------------------------------------------------------
`default_nettype none

`include "substring_first_last_search_core_defines.svh"

module substring_first_last_search_core
    import sfls_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int INDEX_WIDTH = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    sfls_in_if.sink               i_in,
    sfls_out_if.source            o_out,
    input  wire                   i_cfg_we,
    input  t_cfg_addr             i_cfg_addr,
    input  wire  [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;

    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [LEN_REG_W-1:0]  r_pat_len;
    logic                  r_dir;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;

    logic                  r_out_valid;
    t_result               r_result;

    logic [CMP_W-1:0]      len_ext;
    logic [CMP_W-1:0]      len_act;
    logic [LEN_W-1:0]      plen;
    logic                  out_free;
    t_step                 step;
    logic                  hit;
    t_result               n_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_REG_W'(1);
            r_dir     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PATTERN_LOW:      r_pat_lo  <= i_cfg_wdata;
                CFG_PATTERN_HIGH:     r_pat_hi  <= i_cfg_wdata;
                CFG_PATTERN_LENGTH:   r_pat_len <= i_cfg_wdata[LEN_REG_W-1:0];
                CFG_SEARCH_DIRECTION: r_dir     <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // A zero length acts as one; lengths past the window saturate.
    always_comb begin
        len_ext = CMP_W'(r_pat_len);
        if (len_ext == '0) begin
            len_act = CMP_W'(1);
        end else if (len_ext > CMP_W'(MAX_PATTERN)) begin
            len_act = CMP_W'(MAX_PATTERN);
        end else begin
            len_act = len_ext;
        end
        plen = len_act[LEN_W-1:0];
    end

    assign out_free     = !r_out_valid || o_out.ready;
    assign step.advance = r_in_valid && (!r_in_last || out_free);
    assign step.last    = r_in_last;
    assign i_in.ready   = !r_in_valid || step.advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (step.advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.text_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    sfls_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_pat_lo (r_pat_lo),
        .i_pat_hi (r_pat_hi),
        .i_plen   (plen),
        .o_hit    (hit)
    );

    sfls_track #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .LEN_W       (LEN_W)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_hit    (hit),
        .i_plen   (plen),
        .i_dir    (r_dir),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step.advance && step.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.advance && step.last) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_result.found;
    assign o_out.match_index = r_result.match_index;
    assign o_out.status      = r_result.status;

    `SFLS_ASSERT_SAME(a_no_match_zero_index, i_clk, i_rst_n,
        (o_out.valid && o_out.status != ST_FOUND),
        (!o_out.found && o_out.match_index == '0))

    `SFLS_ASSERT_NEXT(a_final_byte_held, i_clk, i_rst_n,
        (r_in_valid && r_in_last && !out_free),
        (r_in_valid && r_in_last))

    `SFLS_ASSERT_NEXT(a_final_byte_yields_word, i_clk, i_rst_n,
        (step.advance && step.last),
        (o_out.valid))

endmodule

`default_nettype wire

FILE: dv/sfls_search_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Substring search result checker
// Watches the text and result channels and the configuration port. It keeps
// its own copy of the search state, predicts the result of every text and
// compares each result word with the oldest prediction, field by field.
// ---------------------------------------------------------------------------

module sfls_search_checker
    import sfls_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    sfls_in_if                   in_mon,
    sfls_out_if                  out_mon,
    input  wire                  i_cfg_we,
    input  t_cfg_addr            i_cfg_addr,
    input  wire [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int WINDOW = 16;

    logic [7:0]         recent [WINDOW];
    logic [MATCH_W-1:0] text_count;
    bit                 match_held;
    logic [MATCH_W-1:0] held_start;

    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len;
    logic        report_last;

    t_result expected_results [$];

    function automatic int unsigned active_length();
        int unsigned n;
        n = 32'(pat_len);
        if (n == 0) begin
            n = 1;
        end
        if (n > WINDOW) begin
            n = WINDOW;
        end
        return n;
    endfunction

    function automatic logic [7:0] pattern_at(input int unsigned k);
        if (k < 8) begin
            return pat_lo[8*k +: 8];
        end
        return pat_hi[8*(k-8) +: 8];
    endfunction

    task automatic clear_text();
        for (int i = 0; i < WINDOW; i++) begin
            recent[i] = '0;
        end
        text_count = '0;
        match_held = 1'b0;
        held_start = '0;
    endtask

    task automatic predict_text_byte(input logic [7:0] b, input logic is_last);
        int unsigned plen;
        bit          hit;
        t_result     r;
        plen = active_length();
        for (int i = WINDOW - 1; i > 0; i--) begin
            recent[i] = recent[i-1];
        end
        recent[0] = b;
        if (text_count != '1) begin
            text_count = text_count + 1'b1;
        end
        if (text_count >= plen) begin
            hit = 1'b1;
            for (int k = 0; k < plen; k++) begin
                if (recent[plen-1-k] != pattern_at(k)) begin
                    hit = 1'b0;
                end
            end
            if (hit && (report_last || !match_held)) begin
                match_held = 1'b1;
                held_start = text_count - MATCH_W'(plen);
            end
        end
        if (is_last) begin
            r.found       = 1'b0;
            r.match_index = '0;
            if (text_count < plen) begin
                r.status = ST_TOO_LONG;
            end else if (match_held) begin
                r.found       = 1'b1;
                r.match_index = held_start;
                r.status      = ST_FOUND;
            end else begin
                r.status = ST_NOT_FOUND;
            end
            expected_results.push_back(r);
            clear_text();
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        o_fail_count++;
        $display("%0t: result %0d field %s mismatch: expected %0d, actual %0d",
                 $time, o_checked, field, want, got);
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            pat_lo      = '0;
            pat_hi      = '0;
            pat_len     = 5'd1;
            report_last = 1'b0;
            clear_text();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PATTERN_LOW:      pat_lo = i_cfg_wdata;
                    CFG_PATTERN_HIGH:     pat_hi = i_cfg_wdata;
                    CFG_PATTERN_LENGTH:   pat_len = i_cfg_wdata[4:0];
                    CFG_SEARCH_DIRECTION: report_last = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready) begin
                predict_text_byte(in_mon.text_byte, in_mon.last_byte);
            end
            if (out_mon.valid && out_mon.ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result word: expected none, actual found %0d index %0d status %0d",
                             $time, out_mon.found, out_mon.match_index, out_mon.status);
                end else begin
                    want = expected_results.pop_front();
                    if (out_mon.found !== want.found) begin
                        report_mismatch("found", 32'(want.found), 32'(out_mon.found));
                    end
                    if (out_mon.match_index !== want.match_index) begin
                        report_mismatch("match_index", want.match_index, out_mon.match_index);
                    end
                    if (out_mon.status !== want.status) begin
                        report_mismatch("status", 32'(want.status), 32'(out_mon.status));
                    end
                end
                o_checked++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: dv/tb_substring_first_last_search_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Substring first/last search core testbench
// Streams directed and random texts through the core under several flow
// control profiles and pattern settings; a checker beside the core predicts
// and compares every result word.
// ---------------------------------------------------------------------------

module tb_substring_first_last_search_core;
    import sfls_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 70;

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_we;
    t_cfg_addr       cfg_addr;
    logic [63:0]     cfg_wdata;

    int src_idle_pct;
    int sink_stall_pct;
    int bytes_sent;
    int texts_sent;
    int cycle_count;
    int fail_count;
    int pending;
    int checked;

    logic [7:0]  pattern_bytes [16];
    int unsigned pattern_len;
    bit          narrow_alphabet;
    logic [7:0]  text [$];

    sfls_in_if  in_ch();
    sfls_out_if out_ch();

    substring_first_last_search_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    sfls_search_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 cycle_count, pending);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic write_reg(input t_cfg_addr a, input logic [63:0] v);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_addr  = a;
        cfg_wdata = v;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_pattern(input logic [4:0] len_reg, input bit dir, input bit junk);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] len_word;
        logic [63:0] dir_word;
        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = pattern_bytes[k];
            hi[8*k +: 8] = pattern_bytes[k+8];
        end
        len_word      = junk ? {$urandom, $urandom} : 64'd0;
        len_word[4:0] = len_reg;
        dir_word      = junk ? {$urandom, $urandom} : 64'd0;
        dir_word[0]   = dir;
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LENGTH, len_word);
        write_reg(CFG_SEARCH_DIRECTION, dir_word);
        pattern_len = (len_reg == 0) ? 1 : ((len_reg > 16) ? 16 : len_reg);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.text_byte = b;
        in_ch.last_byte = is_last;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        bytes_sent++;
        if (is_last) begin
            texts_sent++;
        end
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++) begin
            send_byte(text[i], i == text.size() - 1);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_pattern();
        logic [7:0]  sym_a;
        logic [7:0]  sym_b;
        logic [4:0]  len_reg;
        sym_a           = 8'($urandom_range(255));
        sym_b           = 8'($urandom_range(255));
        narrow_alphabet = ($urandom_range(9) < 7);
        for (int k = 0; k < 16; k++) begin
            if (narrow_alphabet) begin
                pattern_bytes[k] = $urandom_range(1) ? sym_a : sym_b;
            end else begin
                pattern_bytes[k] = 8'($urandom_range(255));
            end
        end
        case ($urandom_range(9))
            0: len_reg = 5'd0;
            1: len_reg = 5'd31;
            2: len_reg = 5'd16;
            3: len_reg = 5'($urandom_range(30, 17));
            4: len_reg = 5'd1;
            5: len_reg = 5'($urandom_range(15, 6));
            default: len_reg = 5'($urandom_range(5, 1));
        endcase
        load_pattern(len_reg, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic build_text();
        int unsigned len;
        int unsigned sel;
        int unsigned flip;
        text.delete();
        if ($urandom_range(4) == 0) begin
            len = $urandom_range(pattern_len, 1);
        end else begin
            len = pattern_len + $urandom_range(14);
        end
        while (text.size() < len) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                // Whole pattern copies, some with one byte corrupted.
                flip = (sel < 35) ? pattern_len : $urandom_range(pattern_len - 1);
                for (int k = 0; k < pattern_len && text.size() < len; k++) begin
                    text.push_back((k == flip) ? ~pattern_bytes[k] : pattern_bytes[k]);
                end
            end else if (sel < 60 || !narrow_alphabet) begin
                text.push_back(8'($urandom_range(255)));
            end else begin
                text.push_back(pattern_bytes[$urandom_range(pattern_len - 1)]);
            end
        end
    endtask

    initial begin
        int phase_start;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = CFG_PATTERN_LOW;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.text_byte = '0;
        in_ch.last_byte = 1'b0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        bytes_sent      = 0;
        texts_sent      = 0;
        pattern_len     = 1;
        for (int k = 0; k < 16; k++) begin
            pattern_bytes[k] = '0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset pattern is a single zero byte searched for its first match.
        text = '{8'hFF, 8'h00};
        send_text();
        text = '{8'hFF};
        send_text();
        settle();

        // Zero length behaves as one.
        pattern_bytes[0] = 8'hAB;
        load_pattern(5'd0, 1'b0, 1'b1);
        text = '{8'hAB};
        send_text();
        settle();

        // Oversized length saturates to sixteen; a short text is too short.
        load_pattern(5'd31, 1'b0, 1'b1);
        text = '{8'h00, 8'hFF};
        send_text();
        settle();

        // Last occurrence of a two byte pattern that appears twice in the text.
        pattern_bytes[0] = 8'h61;
        pattern_bytes[1] = 8'h62;
        load_pattern(5'd2, 1'b1, 1'b1);
        text = '{8'h61, 8'h62, 8'h61, 8'h62};
        send_text();
        settle();

        // Full length pattern matching a text of exactly its length.
        for (int k = 0; k < 16; k++) begin
            pattern_bytes[k] = k[0] ? 8'h00 : 8'hFF;
        end
        load_pattern(5'd17, 1'b0, 1'b0);
        text.delete();
        for (int k = 0; k < 16; k++) begin
            text.push_back(pattern_bytes[k]);
        end
        send_text();
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
                default: begin src_idle_pct = 38; sink_stall_pct = 38; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                random_pattern();
                repeat (5) begin
                    build_text();
                    send_text();
                end
                settle();
            end
        end

        settle();
        repeat (10) @(negedge i_clk);
        $display("Sent %0d text bytes in %0d texts under four flow control profiles; %0d results compared.",
                 bytes_sent, texts_sent, checked);
        $display("Pattern lengths ranged over 0, 1 to 16 and oversized values, in both search directions.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: substring_first_last_search_core.f
+incdir+hw/rtl
hw/rtl/sfls_pkg.sv
hw/rtl/sfls_in_if.sv
hw/rtl/sfls_out_if.sv
hw/rtl/sfls_window.sv
hw/rtl/sfls_track.sv
hw/rtl/substring_first_last_search_core.sv
dv/sfls_search_checker.sv
dv/tb_substring_first_last_search_core.sv
